// ----- hw/rtl/pnk_pkg.sv -----
`default_nettype none
package pnk_pkg;

  localparam int CHAR_W                = 8;
  localparam int KEY_W                 = 17;
  localparam int DIGIT_VALUE_WIDTH_DEF = 16;
  localparam int DIGIT_VALUE_WIDTH_MIN = 8;
  localparam int DIGIT_VALUE_WIDTH_MAX = 31;

  localparam logic signed [KEY_W-1:0] MIDDLE_C = KEY_W'(60);

  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_G = 8'h47;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_G = 8'h67;
  localparam logic [CHAR_W-1:0] CH_UPPER_K = 8'h4B;
  localparam logic [CHAR_W-1:0] CH_LOWER_K = 8'h6B;
  localparam logic [CHAR_W-1:0] CH_FLAT    = 8'h62;
  localparam logic [CHAR_W-1:0] CH_SHARP   = 8'h23;
  localparam logic [CHAR_W-1:0] CH_DSHARP  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;

  typedef struct packed {
    logic       letter;
    logic [3:0] pclass;
    logic       key_k;
    logic       flat;
    logic       sharp;
    logic       dsharp;
    logic       minus;
    logic       plus;
    logic       digit;
    logic [3:0] dval;
  } pnk_char_t;

  function automatic logic [3:0] letter_class(input logic [2:0] idx);
    logic [3:0] pc;
    case (idx)
      3'd0:    pc = 4'd9;
      3'd1:    pc = 4'd11;
      3'd2:    pc = 4'd0;
      3'd3:    pc = 4'd2;
      3'd4:    pc = 4'd4;
      3'd5:    pc = 4'd5;
      3'd6:    pc = 4'd7;
      default: pc = 4'd0;
    endcase
    return pc;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/pitch_name_to_key_number_parser_unit.sv -----
// A result passes through the input register, then the parse state and result
//   register, after its last character is accepted.
// Throughput: one character per cycle unless stalled; the parse state is updated as each character is taken.
// Stalls only when a last character meets an output result not yet taken.
// Reset (rst, synchronous): clears input and output valid and returns the
//   parse state to the start of a name.
`default_nettype none
module pitch_name_to_key_number_parser_unit
  import pnk_pkg::*;
#(
  parameter int DIGIT_VALUE_WIDTH = DIGIT_VALUE_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [CHAR_W-1:0]   char_code,
  input  wire logic                last_char,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [KEY_W-1:0]  key_value,
  output logic                     delta_flag,
  output logic                     well_formed
);

  logic              s1_valid;
  logic [CHAR_W-1:0] s1_char;
  logic              s1_last;
  logic              s1_ready;
  pnk_char_t         s1_cls;

  assign in_ready = !s1_valid || s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
      s1_char  <= char_code;
      s1_last  <= last_char;
    end
  end

  pnk_char_decode u_decode (
    .char_code (s1_char),
    .cls       (s1_cls)
  );

  pnk_parser #(
    .DIGIT_VALUE_WIDTH (DIGIT_VALUE_WIDTH)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (s1_valid),
    .item_ready  (s1_ready),
    .cls         (s1_cls),
    .item_last   (s1_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .key_value   (key_value),
    .delta_flag  (delta_flag),
    .well_formed (well_formed)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/pnk_char_decode.sv -----
`default_nettype none
module pnk_char_decode
  import pnk_pkg::*;
(
  input  wire logic [CHAR_W-1:0] char_code,
  output pnk_char_t              cls
);

  logic [2:0] letter_idx;
  logic [7:0] digit_off;

  assign letter_idx = 3'(char_code[2:0] - 3'd1);
  assign digit_off  = char_code - CH_ZERO;

  always_comb begin
    cls.letter = ((char_code >= CH_UPPER_A) && (char_code <= CH_UPPER_G)) ||
                 ((char_code >= CH_LOWER_A) && (char_code <= CH_LOWER_G));
    cls.pclass = letter_class(letter_idx);
    cls.key_k  = (char_code == CH_UPPER_K) || (char_code == CH_LOWER_K);
    cls.flat   = (char_code == CH_FLAT);
    cls.sharp  = (char_code == CH_SHARP);
    cls.dsharp = (char_code == CH_DSHARP);
    cls.minus  = (char_code == CH_MINUS);
    cls.plus   = (char_code == CH_PLUS);
    cls.digit  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    cls.dval   = digit_off[3:0];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/pnk_parser.sv -----
`default_nettype none
module pnk_parser
  import pnk_pkg::*;
#(
  parameter int DIGIT_VALUE_WIDTH = DIGIT_VALUE_WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    item_valid,
  output logic                         item_ready,
  input  wire pnk_char_t               cls,
  input  wire logic                    item_last,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [KEY_W-1:0]      key_value,
  output logic                         delta_flag,
  output logic                         well_formed
);

  localparam int W = DIGIT_VALUE_WIDTH;

  typedef enum logic [3:0] {
    PH_START,
    PH_LETTER,
    PH_FLAT,
    PH_ACCID,
    PH_MINUS,
    PH_OCTAVE,
    PH_K,
    PH_SIGN,
    PH_DIGITS
  } phase_t;

  typedef enum logic [1:0] {
    SIGN_NONE,
    SIGN_PLUS,
    SIGN_MINUS
  } sign_t;

  phase_t             parse_phase, parse_phase_next;
  logic signed [4:0]  pitch_offset, pitch_offset_next;
  logic               minus_seen, minus_seen_next;
  logic [3:0]         octave_digit, octave_digit_next;
  logic [W-1:0]       digit_value, digit_value_next;
  sign_t              sign_mode, sign_mode_next;
  logic               syntax_error, syntax_error_next;

  logic               take;
  logic               take_last;
  logic [W+3:0]       mac;
  logic [W-1:0]       dv_sat;
  logic [3:0]         oct_p1;
  logic [7:0]         oct_term;
  logic signed [KEY_W-1:0] key_note;
  logic [KEY_W-1:0]   dv17;
  logic signed [KEY_W-1:0] key_k;
  logic               good_note;
  logic               good_k;
  logic signed [KEY_W-1:0] key_res;
  logic               delta_res;

  assign take       = item_valid && (!item_last || !out_valid || out_ready);
  assign item_ready = take;
  assign take_last  = take && item_last;

  assign mac    = ({4'b0, digit_value} << 3) + ({4'b0, digit_value} << 1) +
                  (W+4)'(cls.dval);
  assign dv_sat = (|mac[W+3:W]) ? {W{1'b1}} : mac[W-1:0];

  always_comb begin
    logic note_tail;
    logic digit_step;
    note_tail         = 1'b0;
    digit_step        = 1'b0;
    parse_phase_next  = parse_phase;
    pitch_offset_next = pitch_offset;
    minus_seen_next   = minus_seen;
    octave_digit_next = octave_digit;
    digit_value_next  = digit_value;
    sign_mode_next    = sign_mode;
    syntax_error_next = syntax_error;
    if (!syntax_error) begin
      unique case (parse_phase)
        PH_START: begin
          if (cls.letter) begin
            pitch_offset_next = $signed({1'b0, cls.pclass});
            parse_phase_next  = PH_LETTER;
          end else if (cls.key_k) begin
            parse_phase_next = PH_K;
          end else begin
            syntax_error_next = 1'b1;
          end
        end
        PH_LETTER: begin
          if (cls.flat) begin
            pitch_offset_next = pitch_offset - 5'sd1;
            parse_phase_next  = PH_FLAT;
          end else if (cls.sharp) begin
            pitch_offset_next = pitch_offset + 5'sd1;
            parse_phase_next  = PH_ACCID;
          end else if (cls.dsharp) begin
            pitch_offset_next = pitch_offset + 5'sd2;
            parse_phase_next  = PH_ACCID;
          end else begin
            note_tail = 1'b1;
          end
        end
        PH_FLAT: begin
          if (cls.flat) begin
            pitch_offset_next = pitch_offset - 5'sd1;
            parse_phase_next  = PH_ACCID;
          end else begin
            note_tail = 1'b1;
          end
        end
        PH_ACCID: note_tail = 1'b1;
        PH_MINUS: begin
          if (cls.digit) begin
            octave_digit_next = cls.dval;
            parse_phase_next  = PH_OCTAVE;
          end else begin
            syntax_error_next = 1'b1;
          end
        end
        PH_K: begin
          if (cls.plus) begin
            sign_mode_next   = SIGN_PLUS;
            parse_phase_next = PH_SIGN;
          end else if (cls.minus) begin
            sign_mode_next   = SIGN_MINUS;
            parse_phase_next = PH_SIGN;
          end else begin
            digit_step = 1'b1;
          end
        end
        PH_SIGN, PH_DIGITS: digit_step = 1'b1;
        default: syntax_error_next = 1'b1;
      endcase
      if (note_tail) begin
        if (cls.minus) begin
          minus_seen_next  = 1'b1;
          parse_phase_next = PH_MINUS;
        end else if (cls.digit) begin
          octave_digit_next = cls.dval;
          parse_phase_next  = PH_OCTAVE;
        end else begin
          syntax_error_next = 1'b1;
        end
      end
      if (digit_step) begin
        if (cls.digit) begin
          digit_value_next = dv_sat;
          parse_phase_next = PH_DIGITS;
        end else begin
          syntax_error_next = 1'b1;
        end
      end
    end
  end

  always_comb begin
    oct_p1    = (minus_seen_next && (octave_digit_next == 4'd1)) ? 4'd0 :
                4'(octave_digit_next + 4'd1);
    oct_term  = ({4'b0, oct_p1} << 3) + ({4'b0, oct_p1} << 2);
    key_note  = KEY_W'(pitch_offset_next) + $signed(KEY_W'(oct_term));
    dv17      = KEY_W'(digit_value_next);
    key_k     = (sign_mode_next == SIGN_MINUS) ? -$signed(dv17) : $signed(dv17);
    good_note = !syntax_error_next && (parse_phase_next == PH_OCTAVE);
    good_k    = !syntax_error_next && (parse_phase_next == PH_DIGITS);
    if (good_note) begin
      key_res   = key_note;
      delta_res = 1'b0;
    end else if (good_k) begin
      key_res   = key_k;
      delta_res = (sign_mode_next != SIGN_NONE);
    end else begin
      key_res   = MIDDLE_C;
      delta_res = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase  <= PH_START;
      pitch_offset <= '0;
      minus_seen   <= 1'b0;
      octave_digit <= '0;
      digit_value  <= '0;
      sign_mode    <= SIGN_NONE;
      syntax_error <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (take_last) begin
        parse_phase  <= PH_START;
        pitch_offset <= '0;
        minus_seen   <= 1'b0;
        octave_digit <= '0;
        digit_value  <= '0;
        sign_mode    <= SIGN_NONE;
        syntax_error <= 1'b0;
        out_valid    <= 1'b1;
        key_value    <= key_res;
        delta_flag   <= delta_res;
        well_formed  <= good_note || good_k;
      end else if (take) begin
        parse_phase  <= parse_phase_next;
        pitch_offset <= pitch_offset_next;
        minus_seen   <= minus_seen_next;
        octave_digit <= octave_digit_next;
        digit_value  <= digit_value_next;
        sign_mode    <= sign_mode_next;
        syntax_error <= syntax_error_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_malformed_gives_middle_c: assert property (@(posedge clk) disable iff (rst)
    out_valid && !well_formed |-> key_value == MIDDLE_C && !delta_flag)
    else $error("malformed name must give middle C without delta");

  a_last_restarts_name: assert property (@(posedge clk) disable iff (rst)
    take_last |=> parse_phase == PH_START && !syntax_error && digit_value == '0
                  && sign_mode == SIGN_NONE && !minus_seen)
    else $error("parse state not cleared after last character");

  a_last_posts_result: assert property (@(posedge clk) disable iff (rst)
    take_last |=> out_valid)
    else $error("last character did not post a result");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    syntax_error && !take_last |=> syntax_error)
    else $error("syntax error dropped inside a name");

  a_no_take_while_blocked: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_last && out_valid && !out_ready |-> !item_ready)
    else $error("last character taken while result slot is full");
`endif

endmodule
`default_nettype wire

// ----- tb/pitch_name_checker.sv -----
module pitch_name_checker
  import pnk_pkg::*;
#(
  parameter int DIGIT_VALUE_WIDTH = DIGIT_VALUE_WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  input  wire logic                    in_ready,
  input  wire logic [CHAR_W-1:0]       char_code,
  input  wire logic                    last_char,
  input  wire logic                    out_valid,
  input  wire logic                    out_ready,
  input  wire logic signed [KEY_W-1:0] key_value,
  input  wire logic                    delta_flag,
  input  wire logic                    well_formed,
  output int                           mismatches,
  output int                           awaited
);

  typedef enum logic [3:0] {
    PH_START, PH_LETTER, PH_FLAT, PH_ACCID, PH_MINUS,
    PH_OCTAVE, PH_K, PH_SIGN, PH_DIGITS
  } parse_phase_t;

  typedef enum logic [1:0] {SIGN_NONE, SIGN_PLUS, SIGN_MINUS} sign_mode_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic                    delta;
    logic                    good;
  } key_result_t;

  localparam longint unsigned DIGIT_MAX = (64'd1 << DIGIT_VALUE_WIDTH) - 64'd1;
  localparam logic [27:0] PITCH_CLASSES = {4'd7, 4'd5, 4'd4, 4'd2, 4'd0, 4'd11, 4'd9};
  localparam int SEMITONES = 12;
  localparam int DECIMAL = 10;

  parse_phase_t    phase;
  sign_mode_t      sign_mode;
  int              pitch_offset;
  logic            minus_seen;
  int              octave_digit;
  longint unsigned digit_value;
  logic            syntax_error;

  key_result_t key_results[$];
  key_result_t want;

  task automatic clear_name();
    phase = PH_START;
    sign_mode = SIGN_NONE;
    pitch_offset = 0;
    minus_seen = 1'b0;
    octave_digit = 0;
    digit_value = 0;
    syntax_error = 1'b0;
  endtask

  task automatic take_char(input logic [CHAR_W-1:0] c);
    logic is_dig;
    logic note_tail;
    longint unsigned acc;
    is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
    note_tail = 1'b0;
    if (syntax_error) return;
    case (phase)
      PH_START: begin
        if (c >= CH_UPPER_A && c <= CH_UPPER_G) begin
          pitch_offset = int'(PITCH_CLASSES[4*int'(c - CH_UPPER_A) +: 4]);
          phase = PH_LETTER;
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_G) begin
          pitch_offset = int'(PITCH_CLASSES[4*int'(c - CH_LOWER_A) +: 4]);
          phase = PH_LETTER;
        end else if (c == CH_UPPER_K || c == CH_LOWER_K) begin
          phase = PH_K;
        end else begin
          syntax_error = 1'b1;
        end
      end
      PH_LETTER: begin
        if (c == CH_FLAT) begin
          pitch_offset -= 1;
          phase = PH_FLAT;
        end else if (c == CH_SHARP) begin
          pitch_offset += 1;
          phase = PH_ACCID;
        end else if (c == CH_DSHARP) begin
          pitch_offset += 2;
          phase = PH_ACCID;
        end else begin
          note_tail = 1'b1;
        end
      end
      PH_FLAT: begin
        if (c == CH_FLAT) begin
          pitch_offset -= 1;
          phase = PH_ACCID;
        end else begin
          note_tail = 1'b1;
        end
      end
      PH_ACCID: note_tail = 1'b1;
      PH_MINUS: begin
        if (is_dig) begin
          octave_digit = int'(c - CH_ZERO);
          phase = PH_OCTAVE;
        end else begin
          syntax_error = 1'b1;
        end
      end
      PH_K, PH_SIGN, PH_DIGITS: begin
        if (phase == PH_K && c == CH_PLUS) begin
          sign_mode = SIGN_PLUS;
          phase = PH_SIGN;
        end else if (phase == PH_K && c == CH_MINUS) begin
          sign_mode = SIGN_MINUS;
          phase = PH_SIGN;
        end else if (is_dig) begin
          acc = digit_value * DECIMAL + longint'(c - CH_ZERO);
          digit_value = (acc > DIGIT_MAX) ? DIGIT_MAX : acc;
          phase = PH_DIGITS;
        end else begin
          syntax_error = 1'b1;
        end
      end
      default: syntax_error = 1'b1;
    endcase
    if (note_tail) begin
      if (c == CH_MINUS) begin
        minus_seen = 1'b1;
        phase = PH_MINUS;
      end else if (is_dig) begin
        octave_digit = int'(c - CH_ZERO);
        phase = PH_OCTAVE;
      end else begin
        syntax_error = 1'b1;
      end
    end
  endtask

  function automatic key_result_t name_result();
    key_result_t r;
    int oct;
    r.key = MIDDLE_C;
    r.delta = 1'b0;
    r.good = 1'b0;
    if (!syntax_error && phase == PH_OCTAVE) begin
      oct = (minus_seen && octave_digit == 1) ? -1 : octave_digit;
      r.key = KEY_W'(pitch_offset + SEMITONES * (oct + 1));
      r.good = 1'b1;
    end else if (!syntax_error && phase == PH_DIGITS) begin
      if (sign_mode == SIGN_MINUS) r.key = KEY_W'(-longint'(digit_value));
      else r.key = KEY_W'(digit_value);
      r.delta = (sign_mode != SIGN_NONE);
      r.good = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint exp);
    $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, exp);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_name();
      key_results.delete();
      mismatches = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (key_results.size() == 0) begin
          report_mismatch("unrequested result, key_value", key_value, 0);
        end else begin
          want = key_results.pop_front();
          if (key_value !== want.key) report_mismatch("key_value", key_value, want.key);
          if (delta_flag !== want.delta) report_mismatch("delta_flag", delta_flag, want.delta);
          if (well_formed !== want.good) report_mismatch("well_formed", well_formed, want.good);
        end
      end
      if (in_valid && in_ready) begin
        take_char(char_code);
        if (last_char) begin
          key_results.push_back(name_result());
          clear_name();
        end
      end
    end
    awaited = key_results.size();
  end

endmodule

// ----- tb/tb_pitch_name_to_key_number_parser_unit.sv -----
module tb_pitch_name_to_key_number_parser_unit;
  import pnk_pkg::*;

  typedef logic [CHAR_W-1:0] name_bytes_t[$];

  localparam int STALL_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_CHARS   = 300;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [CHAR_W-1:0]       char_code = '0;
  logic                    last_char = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [KEY_W-1:0] key_value;
  logic                    delta_flag;
  logic                    well_formed;

  int mismatches;
  int awaited;
  int send_idle = 14;
  int recv_idle = 75;
  int stalled_cycles;

  always #5 clk = ~clk;

  pitch_name_to_key_number_parser_unit uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .char_code  (char_code),
    .last_char  (last_char),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .key_value  (key_value),
    .delta_flag (delta_flag),
    .well_formed(well_formed)
  );

  pitch_name_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .char_code  (char_code),
    .last_char  (last_char),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .key_value  (key_value),
    .delta_flag (delta_flag),
    .well_formed(well_formed),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst) begin
      stalled_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    char_code <= c;
    last_char <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_name(input name_bytes_t name);
    foreach (name[i]) send_char(name[i], i == name.size() - 1);
  endtask

  task automatic send_text(input string s);
    name_bytes_t name;
    name = {};
    for (int i = 0; i < s.len(); i++) name.push_back(s[i]);
    send_name(name);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (awaited != 0);
  endtask

  function automatic logic [CHAR_W-1:0] random_digit();
    return CHAR_W'(CH_ZERO + $urandom_range(0, 9));
  endfunction

  task automatic build_name(output name_bytes_t name);
    int form;
    int n;
    int pos;
    name = {};
    form = $urandom_range(0, 99);
    if (form < 10) begin
      n = $urandom_range(1, 5);
      repeat (n) name.push_back(CHAR_W'($urandom_range(0, 255)));
    end else begin
      if (form < 50) begin
        name.push_back(CHAR_W'(($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A)
                               + $urandom_range(0, 6)));
        case ($urandom_range(0, 4))
          1: name.push_back(CH_FLAT);
          2: name.push_back(CH_SHARP);
          3: name.push_back(CH_DSHARP);
          4: begin
            name.push_back(CH_FLAT);
            name.push_back(CH_FLAT);
          end
          default: ;
        endcase
        if ($urandom_range(0, 3) == 0) name.push_back(CH_MINUS);
        name.push_back(random_digit());
      end else begin
        name.push_back($urandom_range(0, 1) ? CH_UPPER_K : CH_LOWER_K);
        case ($urandom_range(0, 2))
          1: name.push_back(CH_PLUS);
          2: name.push_back(CH_MINUS);
          default: ;
        endcase
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 3);
        repeat (n) name.push_back(random_digit());
      end
      if (form >= 80) begin
        if ($urandom_range(0, 1)) begin
          n = $urandom_range(1, name.size() - 1);
          repeat (n) void'(name.pop_back());
        end else begin
          pos = $urandom_range(0, name.size() - 1);
          case ($urandom_range(0, 4))
            0: name[pos] = CH_MINUS;
            1: name[pos] = CH_PLUS;
            2: name[pos] = CH_FLAT;
            3: name[pos] = random_digit();
            default: name[pos] = CHAR_W'($urandom_range(0, 255));
          endcase
        end
      end
    end
  endtask

  task automatic run_phase(input int s_idle, input int r_idle);
    int sent;
    name_bytes_t name;
    send_idle = s_idle;
    recv_idle = r_idle;
    sent = 0;
    while (sent < PHASE_CHARS) begin
      build_name(name);
      send_name(name);
      sent += name.size();
    end
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_text("C-1");
    send_text("G#9");
    send_text("cbb4");
    send_text("K65536");
    send_text("k-9");
    send_text("k-");
    send_char(8'hFF, 1'b1);
    send_name('{CH_UPPER_A, 8'h00, CH_ZERO});
    wait_drained();

    run_phase(14, 75);
    run_phase(75, 14);
    run_phase(0, 0);

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && awaited == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
